FILE: sv/uart16_pkg.sv
// ----------------------------------------------------------------------------
// uart16_pkg
// Shared types and constants for the 16-bit UART transceiver core.
// ----------------------------------------------------------------------------
package uart16_pkg;

  // Fixed widths of the item fields
  localparam int WORD_W = 16;
  localparam int TICK_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SAMPLE = 2'd1;

  localparam logic [TICK_W-1:0] BIT_TICKS_RST    = 8'd80;
  localparam logic [TICK_W-1:0] START_SAMPLE_RST = 8'd40;
  localparam logic [TICK_W-1:0] TICK_MAX         = 8'd255;

  // Frame phase, shared by receiver and transmitter
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  // Saturating tick counter increment
  function automatic logic [TICK_W-1:0] tick_up(input logic [TICK_W-1:0] c);
    tick_up = (c == TICK_MAX) ? TICK_MAX : c + 1'b1;
  endfunction

endpackage

FILE: sv/uart_16bit_transceiver_core.sv
// ----------------------------------------------------------------------------
// uart_16bit_transceiver_core
// UART receiver and transmitter, start bit + DATA_BITS data bits (LSB first)
// + stop bit, advanced by one tick per accepted input item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o | rx_line, tx_request, tx_word
//  out     | source    | out_valid_o/out_stall_i | tx_line, tx_busy, rx_valid,
//          |           |                        | rx_word, rx_frame_error,
//          |           |                        | error_latched
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One item per cycle while in_stall_o is low: each accepted item is one tick;
//  the whole tick update of both state machines is one combinational pass into
//  the state and the output register, so a result shows the cycle after its item.
//  Reset (rst_ni, async, low) puts both sides idle, clears the error latch
//  and loads bit_ticks = 80, start_sample_ticks = 40.
//  An item is taken while the output register is empty or being emptied;
//  in_stall_o only rises when a held result is stalled downstream.
//
module uart_16bit_transceiver_core
  import uart16_pkg::*;
#(
  parameter int DATA_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  rx_line_i,
  input  logic                  tx_request_i,
  input  logic [WORD_W-1:0]     tx_word_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  tx_line_o,
  output logic                  tx_busy_o,
  output logic                  rx_valid_o,
  output logic [WORD_W-1:0]     rx_word_o,
  output logic                  rx_frame_error_o,
  output logic                  error_latched_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // bit index has to hold DATA_BITS itself
  localparam int IDX_W = $clog2(DATA_BITS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic accept;
  logic out_valid_q, out_valid_d;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TICK_W-1:0] bit_ticks_q, start_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q   <= BIT_TICKS_RST;
      start_ticks_q <= START_SAMPLE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BIT_TICKS:    bit_ticks_q   <= cfg_data_i;
        CFG_START_SAMPLE: start_ticks_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  phase_e                 rx_phase_q, rx_phase_d;
  logic [TICK_W-1:0]      rx_cnt_q, rx_cnt_d;
  logic [IDX_W-1:0]       rx_idx_q, rx_idx_d;
  logic [DATA_BITS-1:0]   rx_shift_q, rx_shift_d;
  logic                   rx_start_bad_q, rx_start_bad_d;
  logic                   err_q, err_d;
  phase_e                 tx_phase_q, tx_phase_d;
  logic [TICK_W-1:0]      tx_cnt_q, tx_cnt_d;
  logic [IDX_W-1:0]       tx_idx_q, tx_idx_d;
  logic [DATA_BITS-1:0]   tx_shift_q, tx_shift_d;

  // result of this tick
  logic              res_line, res_busy, res_valid, res_ferr;
  logic [WORD_W-1:0] res_word;

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------
  always_comb begin
    logic [TICK_W-1:0] cnt_inc;
    logic [IDX_W-1:0]  idx_inc;
    cnt_inc        = tick_up(rx_cnt_q);
    idx_inc        = rx_idx_q + 1'b1;
    rx_phase_d     = rx_phase_q;
    rx_cnt_d       = rx_cnt_q;
    rx_idx_d       = rx_idx_q;
    rx_shift_d     = rx_shift_q;
    rx_start_bad_d = rx_start_bad_q;
    err_d          = err_q;
    res_valid      = 1'b0;
    res_word       = '0;
    res_ferr       = 1'b0;
    case (rx_phase_q)
      PH_IDLE: begin
        // falling edge: start counting towards the start-bit sample
        if (!rx_line_i) begin
          rx_phase_d = PH_START;
          rx_cnt_d   = '0;
        end
      end
      PH_START: begin
        rx_cnt_d = cnt_inc;
        if (cnt_inc >= start_ticks_q) begin
          // a high start bit is only remembered, reception carries on
          rx_start_bad_d = rx_line_i;
          rx_cnt_d       = '0;
          rx_idx_d       = '0;
          rx_phase_d     = PH_DATA;
        end
      end
      PH_DATA: begin
        rx_cnt_d = cnt_inc;
        if (cnt_inc >= bit_ticks_q) begin
          rx_cnt_d   = '0;
          rx_shift_d = {rx_line_i, rx_shift_q[DATA_BITS-1:1]};
          rx_idx_d   = idx_inc;
          if (idx_inc >= LAST_IDX) rx_phase_d = PH_STOP;
        end
      end
      PH_STOP: begin
        rx_cnt_d = cnt_inc;
        if (cnt_inc >= bit_ticks_q) begin
          rx_cnt_d   = '0;
          res_valid  = 1'b1;
          res_word   = WORD_W'(rx_shift_q);
          res_ferr   = rx_start_bad_q || !rx_line_i;
          if (res_ferr) err_d = 1'b1;
          rx_phase_d = PH_IDLE;
        end
      end
      default: rx_phase_d = PH_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Transmitter
  // --------------------------------------------------------------------------
  always_comb begin
    phase_e               ph;
    logic [DATA_BITS-1:0] sh;
    logic [IDX_W-1:0]     idx;
    logic [TICK_W-1:0]    cnt;
    logic [TICK_W-1:0]    cnt_inc;
    ph  = tx_phase_q;
    sh  = tx_shift_q;
    idx = tx_idx_q;
    cnt = tx_cnt_q;
    // request is taken only when idle; the start bit goes out this tick
    if (tx_phase_q == PH_IDLE && tx_request_i) begin
      ph  = PH_START;
      sh  = DATA_BITS'(tx_word_i);
      idx = '0;
      cnt = '0;
    end
    cnt_inc  = tick_up(cnt);
    res_busy = (ph != PH_IDLE);
    case (ph)
      PH_START: res_line = 1'b0;
      PH_DATA:  res_line = sh[0];
      default:  res_line = 1'b1;
    endcase
    tx_phase_d = ph;
    tx_shift_d = sh;
    tx_idx_d   = idx;
    tx_cnt_d   = cnt;
    if (ph != PH_IDLE) begin
      tx_cnt_d = cnt_inc;
      if (cnt_inc >= bit_ticks_q) begin
        tx_cnt_d = '0;
        case (ph)
          PH_START: begin
            tx_phase_d = PH_DATA;
            tx_idx_d   = '0;
          end
          PH_DATA: begin
            tx_shift_d = sh >> 1;
            tx_idx_d   = idx + 1'b1;
            if (IDX_W'(idx + 1'b1) >= LAST_IDX) tx_phase_d = PH_STOP;
          end
          default: tx_phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // State registers, advanced once per accepted item
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase_q     <= PH_IDLE;
      rx_cnt_q       <= '0;
      rx_idx_q       <= '0;
      rx_shift_q     <= '0;
      rx_start_bad_q <= 1'b0;
      err_q          <= 1'b0;
      tx_phase_q     <= PH_IDLE;
      tx_cnt_q       <= '0;
      tx_idx_q       <= '0;
      tx_shift_q     <= '0;
    end else if (accept) begin
      rx_phase_q     <= rx_phase_d;
      rx_cnt_q       <= rx_cnt_d;
      rx_idx_q       <= rx_idx_d;
      rx_shift_q     <= rx_shift_d;
      rx_start_bad_q <= rx_start_bad_d;
      err_q          <= err_d;
      tx_phase_q     <= tx_phase_d;
      tx_cnt_q       <= tx_cnt_d;
      tx_idx_q       <= tx_idx_d;
      tx_shift_q     <= tx_shift_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept)            out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_line_o        <= res_line;
      tx_busy_o        <= res_busy;
      rx_valid_o       <= res_valid;
      rx_word_o        <= res_word;
      rx_frame_error_o <= res_ferr;
      error_latched_o  <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the sticky latch only ever falls through reset
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(err_q))
    else $error("error latch cleared without reset");

  // a reported framing error shows in the latch on the same item
  a_ferr_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_frame_error_o |-> error_latched_o)
    else $error("frame error not latched");

  // no word or error outside a completed reception
  a_rx_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rx_valid_o |-> rx_word_o == '0 && !rx_frame_error_o)
    else $error("rx payload outside rx_valid");

  // an idle transmitter holds the line high
  a_tx_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_busy_o |-> tx_line_o)
    else $error("tx line low while idle");

endmodule
